[rtl/fpa_pkg.sv]
// Package for the Q24.8 fixed-point ALU: sizes, opcodes, pipeline word types.
// Also holds the signed saturation helper. No dependencies.
package fpa_pkg;
	localparam int DW    = 32;
	localparam int FB    = 8;
	localparam int NSTEP = DW + FB;
	localparam int QW    = 2 * DW + 1;
	localparam int LAT   = NSTEP + 3;

	localparam logic [QW-1:0] POS_MAX_Q = {{(QW-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic [QW-1:0] NEG_MAG_Q = POS_MAX_Q + QW'(1);
	localparam logic [DW-1:0] POS_MAX   = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] NEG_MAX   = {1'b1, {(DW-1){1'b0}}};

	typedef enum logic [3:0] {
		OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
		OP_GT = 4'd4, OP_LT = 4'd5, OP_GE = 4'd6, OP_LE = 4'd7,
		OP_EQ = 4'd8, OP_NE = 4'd9, OP_MIN = 4'd10, OP_MAX = 4'd11,
		OP_INC = 4'd12, OP_DEC = 4'd13, OP_TOINT = 4'd14, OP_FROMINT = 4'd15
	} op_t;

	typedef struct packed {
		op_t             op;
		logic            neg;
		logic            a_neg;
		logic            dz;
		logic            cmp;
		logic [DW-1:0]   res;
		logic [2*DW-1:0] prod;
	} side_t;

	typedef struct packed {
		logic [DW-1:0]    r;
		logic [NSTEP-1:0] n;
		logic [NSTEP-1:0] q;
		logic [DW-1:0]    d;
	} div_t;

	typedef struct packed {
		logic [DW-1:0] res;
		logic          ovf;
	} sat_t;

	function automatic sat_t sat_mag(logic [QW-1:0] q, logic neg);
		sat_t s;
		if (neg) begin
			s.ovf = (q > NEG_MAG_Q);
			s.res = s.ovf ? NEG_MAX : DW'(~q + QW'(1));
		end else begin
			s.ovf = (q > POS_MAX_Q);
			s.res = s.ovf ? POS_MAX : DW'(q);
		end
		return s;
	endfunction
endpackage

[rtl/fpa_div_step.sv]
// One restoring division step: shift in a dividend bit, compare, subtract.
// Depends on fpa_pkg.
module fpa_div_step import fpa_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  valid_in,
	input  div_t  din,
	input  side_t sin,
	output logic  valid_out,
	output div_t  dout,
	output side_t sout
);
	logic [DW:0] r_sh;
	logic        ge;
	div_t        nxt;

	always_comb begin
		r_sh    = {din.r, din.n[NSTEP-1]};
		ge      = (r_sh >= {1'b0, din.d});
		nxt.r   = ge ? DW'(r_sh - {1'b0, din.d}) : DW'(r_sh);
		nxt.n   = {din.n[NSTEP-2:0], 1'b0};
		nxt.q   = {din.q[NSTEP-2:0], ge};
		nxt.d   = din.d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_out <= 1'b0;
		else valid_out <= valid_in;
	end

	always_ff @(posedge clk) begin
		dout <= nxt;
		sout <= sin;
	end
endmodule

[rtl/fpa_div.sv]
// Pipelined divider: one quotient bit per stage, side word carried along.
// Depends on fpa_pkg and fpa_div_step.
module fpa_div import fpa_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  valid_in,
	input  div_t  din,
	input  side_t sin,
	output logic  valid_out,
	output div_t  dout,
	output side_t sout
);
	logic  v [NSTEP+1];
	div_t  d [NSTEP+1];
	side_t s [NSTEP+1];

	assign v[0] = valid_in;
	assign d[0] = din;
	assign s[0] = sin;

	for (genvar i = 0; i < NSTEP; i++) begin : g_step
		fpa_div_step u_step (
			.clk(clk), .arst_n(arst_n),
			.valid_in(v[i]), .din(d[i]), .sin(s[i]),
			.valid_out(v[i+1]), .dout(d[i+1]), .sout(s[i+1])
		);
	end

	assign valid_out = v[NSTEP];
	assign dout      = d[NSTEP];
	assign sout      = s[NSTEP];
endmodule

[rtl/fixed_point_alu_q24_8.sv]
// Q24.8 fixed-point ALU, fully pipelined; depends on fpa_pkg and fpa_div.
// Every opcode takes the same path from start to done: the 40-stage
// divider plus operand, multiply and rounding stages.
// Throughput: one word per cycle; busy is always low.
// Reset clears the valid bits only; results are never stalled by the receiver.
module fixed_point_alu_q24_8 import fpa_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [3:0]           op,
	input  logic signed [DW-1:0] operand_a,
	input  logic signed [DW-1:0] operand_b,
	output logic                 done,
	output logic signed [DW-1:0] result,
	output logic                 compare_true,
	output logic                 overflow,
	output logic                 divide_by_zero
);
	op_t           opc;
	logic          lt_ab, lt_ba;
	side_t         side_c, side_s1, side_m, side_s2, side_dq;
	logic [DW-1:0] mag_a_s1, mag_b_s1;
	logic          v_s1, v_s2, v_dq;
	div_t          div_s2, div_dq;
	logic [DW:0]   r2;
	logic [QW-1:0] qd, qm, qsel;
	logic [2*DW:0] pr;
	sat_t          sat;
	logic [DW-1:0] res_c;
	logic          ovf_c, dz_c;

	assign busy = 1'b0;
	assign opc  = op_t'(op);

	always_comb begin
		lt_ab         = operand_a < operand_b;
		lt_ba         = operand_b < operand_a;
		side_c.op     = opc;
		side_c.a_neg  = operand_a[DW-1];
		side_c.neg    = operand_a[DW-1] ^ operand_b[DW-1];
		side_c.dz     = (operand_b == '0);
		side_c.prod   = '0;
		side_c.res    = '0;
		side_c.cmp    = 1'b0;
		unique case (opc)
			OP_ADD:     side_c.res = operand_a + operand_b;
			OP_SUB:     side_c.res = operand_a - operand_b;
			OP_GT:      side_c.cmp = lt_ba;
			OP_LT:      side_c.cmp = lt_ab;
			OP_GE:      side_c.cmp = !lt_ab;
			OP_LE:      side_c.cmp = !lt_ba;
			OP_EQ:      side_c.cmp = (operand_a == operand_b);
			OP_NE:      side_c.cmp = (operand_a != operand_b);
			OP_MIN:     side_c.res = lt_ab ? operand_a : operand_b;
			OP_MAX:     side_c.res = lt_ba ? operand_a : operand_b;
			OP_INC:     side_c.res = operand_a + DW'(1);
			OP_DEC:     side_c.res = operand_a - DW'(1);
			OP_TOINT:   side_c.res = operand_a >>> FB;
			OP_FROMINT: side_c.res = operand_a << FB;
			default:    side_c.res = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		side_s1  <= side_c;
		mag_a_s1 <= operand_a[DW-1] ? DW'(-operand_a) : operand_a;
		mag_b_s1 <= operand_b[DW-1] ? DW'(-operand_b) : operand_b;
	end

	always_comb begin
		side_m      = side_s1;
		side_m.prod = (2*DW)'(mag_a_s1) * (2*DW)'(mag_b_s1);
	end

	always_ff @(posedge clk) begin
		side_s2  <= side_m;
		div_s2.r <= '0;
		div_s2.n <= {mag_a_s1, {FB{1'b0}}};
		div_s2.q <= '0;
		div_s2.d <= mag_b_s1;
	end

	fpa_div u_div (
		.clk(clk), .arst_n(arst_n),
		.valid_in(v_s2), .din(div_s2), .sin(side_s2),
		.valid_out(v_dq), .dout(div_dq), .sout(side_dq)
	);

	always_comb begin
		r2   = {div_dq.r, 1'b0};
		qd   = QW'(div_dq.q) + QW'(r2 >= {1'b0, div_dq.d});
		pr   = {1'b0, side_dq.prod} + (2*DW+1)'(1 << (FB - 1));
		qm   = QW'(pr >> FB);
		qsel = (side_dq.op == OP_MUL) ? qm : qd;
		sat  = sat_mag(qsel, side_dq.neg);
	end

	always_comb begin
		res_c = side_dq.res;
		ovf_c = 1'b0;
		dz_c  = 1'b0;
		if (side_dq.op == OP_MUL) begin
			res_c = sat.res;
			ovf_c = sat.ovf;
		end else if (side_dq.op == OP_DIV) begin
			if (side_dq.dz) begin
				res_c = side_dq.a_neg ? NEG_MAX : POS_MAX;
				dz_c  = 1'b1;
			end else begin
				res_c = sat.res;
				ovf_c = sat.ovf;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= v_dq;
	end

	always_ff @(posedge clk) begin
		compare_true   <= side_dq.cmp;
		overflow       <= ovf_c;
		divide_by_zero <= dz_c;
		result         <= res_c;
	end
endmodule

[rtl/fpa_checker.sv]
// Port-level checker for the fixed-point ALU, bound to the top level.
// Depends on fpa_pkg.
module fpa_checker import fpa_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input logic                 done,
	input logic signed [DW-1:0] result,
	input logic                 compare_true,
	input logic                 overflow,
	input logic                 divide_by_zero
);
	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("done without matching start");
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(overflow && divide_by_zero))
		else $error("overflow and divide_by_zero together");
	a_cmp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && compare_true) |-> (result == '0) && !overflow && !divide_by_zero)
		else $error("compare word carries data");
endmodule

bind fixed_point_alu_q24_8 fpa_checker u_fpa_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.result(result), .compare_true(compare_true), .overflow(overflow),
	.divide_by_zero(divide_by_zero)
);
